// ===== hw/rtl/nugs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nugs_pkg: shared types and constants of the nearest unvisited goal selector
// Item action codes, the orientation record and the arrival threshold
// constants used by the interfaces and the selector datapath.
// ----------------------------------------------------------------------------
package nugs_pkg;

  // Kind of an incoming item
  typedef enum logic {
    ACT_ODOM  = 1'b0,
    ACT_POINT = 1'b1
  } action_e;

  // Orientation quaternion, signed Q1.15 per component
  localparam int QUAT_W = 16;

  typedef struct packed {
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
    logic signed [QUAT_W-1:0] w;
  } quat_t;

  // Arrival threshold register and its square
  localparam int                 THR_W        = 16;
  localparam int                 THR_SQ_W     = 2 * THR_W;
  localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(614 * 614);

endpackage

// ===== hw/rtl/nugs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nugs_if: channel interfaces of the nearest unvisited goal selector
// Input item channel, goal result channel and threshold write channel,
// each a valid/ready handshake with a source and a sink modport.
// ----------------------------------------------------------------------------

// Odometry / candidate point items
interface nugs_item_if
  import nugs_pkg::*;
#(
  parameter int ID_BITS    = 12,
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  action_e                      action;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic        [ID_BITS-1:0]    point_id;
  logic signed [QUAT_W-1:0]     quat_x;
  logic signed [QUAT_W-1:0]     quat_y;
  logic signed [QUAT_W-1:0]     quat_z;
  logic signed [QUAT_W-1:0]     quat_w;
  logic                         is_add;
  logic                         from_removed;
  logic                         last_in_batch;

  modport source (
    output valid, action, pos_x, pos_y, point_id, quat_x, quat_y, quat_z, quat_w,
           is_add, from_removed, last_in_batch,
    input  ready
  );
  modport sink (
    input  valid, action, pos_x, pos_y, point_id, quat_x, quat_y, quat_z, quat_w,
           is_add, from_removed, last_in_batch,
    output ready
  );
endinterface

// Newly chosen goals
interface nugs_goal_if
  import nugs_pkg::*;
#(
  parameter int ID_BITS    = 12,
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic        [ID_BITS-1:0]    goal_id;
  logic signed [COORD_BITS-1:0] goal_x;
  logic signed [COORD_BITS-1:0] goal_y;
  logic signed [QUAT_W-1:0]     goal_qx;
  logic signed [QUAT_W-1:0]     goal_qy;
  logic signed [QUAT_W-1:0]     goal_qz;
  logic signed [QUAT_W-1:0]     goal_qw;
  logic                         goal_from_removed;
  logic                         previous_reached;

  modport source (
    output valid, goal_id, goal_x, goal_y, goal_qx, goal_qy, goal_qz, goal_qw,
           goal_from_removed, previous_reached,
    input  ready
  );
  modport sink (
    input  valid, goal_id, goal_x, goal_y, goal_qx, goal_qy, goal_qz, goal_qw,
           goal_from_removed, previous_reached,
    output ready
  );
endinterface

// Arrival threshold writes
interface nugs_cfg_if
  import nugs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/nugs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nugs_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered
// and returns the old contents on a same-cycle write to the same entry.
// ----------------------------------------------------------------------------
module nugs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/nugs_sqdist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nugs_sqdist: pipelined squared distance between two points
// Stage one registers the absolute differences, stage two the squares;
// the saturating sum is formed combinationally behind the second stage.
// ----------------------------------------------------------------------------
module nugs_sqdist #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  output logic [((2*COORD_BITS+1 > 64) ? 64 : 2*COORD_BITS+1)-1:0] dist_o
);

  localparam int MAG_W  = COORD_BITS;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int DIST_W = (2 * COORD_BITS + 1 > 64) ? 64 : 2 * COORD_BITS + 1;

  logic signed [COORD_BITS:0] dx, dy;
  logic [MAG_W-1:0]           mag_x_d, mag_y_d, mag_x_q, mag_y_q;
  logic [SQ_W-1:0]            sq_x_d, sq_y_d, sq_x_q, sq_y_q;
  logic [SQ_W:0]              sum;
  logic                       ovf;

  // Differences and magnitudes (magnitude always fits COORD_BITS)
  always_comb begin
    dx      = {ax_i[COORD_BITS-1], ax_i} - {bx_i[COORD_BITS-1], bx_i};
    dy      = {ay_i[COORD_BITS-1], ay_i} - {by_i[COORD_BITS-1], by_i};
    mag_x_d = dx[COORD_BITS] ? MAG_W'(-dx) : MAG_W'(dx);
    mag_y_d = dy[COORD_BITS] ? MAG_W'(-dy) : MAG_W'(dy);
  end

  // Squares
  assign sq_x_d = SQ_W'(mag_x_q) * SQ_W'(mag_x_q);
  assign sq_y_d = SQ_W'(mag_y_q) * SQ_W'(mag_y_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_x_q <= mag_x_d;
      mag_y_q <= mag_y_d;
      sq_x_q  <= sq_x_d;
      sq_y_q  <= sq_y_d;
    end
  end

  // Saturating sum; only overflows for coordinates of 32 bits or more
  assign sum    = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign ovf    = |(sum >> DIST_W);
  assign dist_o = ovf ? '1 : sum[DIST_W-1:0];

endmodule

// ===== hw/rtl/nugs_outbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nugs_outbuf: two-entry result buffer
// Head register drives the output channel, a second entry absorbs one more
// result; full is a registered flag so no ready path reaches the input.
// ----------------------------------------------------------------------------
module nugs_outbuf #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic [1:0]   cnt_d, cnt_q;
  logic [W-1:0] head_d, head_q, tail_d, tail_q;
  logic         pop;

  assign pop = (cnt_q != 2'd0) && ready_i;

  // Occupancy and entry moves
  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    if (push_i && !pop) begin
      if (cnt_q == 2'd0) begin
        head_d = data_i;
      end else begin
        tail_d = data_i;
      end
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      head_d = tail_q;
      cnt_d  = cnt_q - 2'd1;
    end else if (push_i && pop) begin
      if (cnt_q == 2'd1) begin
        head_d = data_i;
      end else begin
        head_d = tail_q;
        tail_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = head_q;

endmodule

// ===== hw/rtl/nearest_unvisited_goal_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_unvisited_goal_selector: greedy nearest unvisited goal choice
// Tracks robot position, keeps the nearest unvisited candidate of a batch and
// hands out a new goal once the previous one is reached or none is active.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : odometry items (action = odometry) and candidate points; a batch
//            of candidates ends with last_in_batch set.
//   out_o  : one transaction per batch end that picks a new goal, none else.
//   cfg_i  : arrival radius writes; always ready, take effect next cycle.
// Pipeline: the last item of a batch passes the three-stage bitmap read /
//   square / decide pipe, and its result is then registered in the buffer.
// Throughput: one item per cycle when not stalled. A batch-ending candidate
//   is held off while the previous batch end is still in the first two
//   stages, since its arrival check reads the goal that batch end sets.
// Reset: the two visited bitmaps are cleared one entry per cycle, all
//   2^ID_BITS entries (4096 by default); in_i.ready stays low meanwhile.
// Stall: results queue in a two-entry buffer; when both entries are taken
//   the pipeline freezes and in_i.ready drops until the receiver drains one.
// ----------------------------------------------------------------------------
module nearest_unvisited_goal_selector
  import nugs_pkg::*;
#(
  parameter int ID_BITS    = 12,
  parameter int COORD_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nugs_item_if.sink   in_i,
  nugs_cfg_if.sink    cfg_i,
  nugs_goal_if.source out_o
);

  localparam int DEPTH  = 1 << ID_BITS;
  localparam int DIST_W = (2 * COORD_BITS + 1 > 64) ? 64 : 2 * COORD_BITS + 1;
  localparam int CMP_W  = (DIST_W > THR_SQ_W) ? DIST_W : THR_SQ_W;

  typedef logic        [ID_BITS-1:0]    id_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Visited-bitmap write: which list and which entry
  typedef struct packed {
    logic v;
    logic rem;
    id_t  addr;
  } mark_t;

  // Result record as it sits in the output buffer
  typedef struct packed {
    id_t    id;
    coord_t x;
    coord_t y;
    quat_t  q;
    logic   from_removed;
    logic   reached;
  } res_t;

  function automatic logic wr_hit(mark_t w, logic rem, id_t id);
    return w.v && (w.rem == rem) && (w.addr == id);
  endfunction

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic                clear_q;
  id_t                 clr_cnt_q;
  logic [THR_SQ_W-1:0] thr_sq_q;

  logic                adv, buf_full, accept, last_busy, in_last_pt;

  logic   s1_v_q, s1_point_q, s1_last_q, s1_add_q, s1_from_rem_q;
  id_t    s1_id_q;
  coord_t s1_x_q, s1_y_q;
  quat_t  s1_quat_q;
  logic   s1_rem, s1_seen;

  logic   s2_v_q, s2_point_q, s2_last_q, s2_add_q, s2_rem_q, s2_seen_q;
  id_t    s2_id_q;
  coord_t s2_x_q, s2_y_q;
  quat_t  s2_quat_q;
  logic   s2_seen;

  logic   s3_v_q, s3_point_q, s3_last_q, s3_add_q, s3_rem_q, s3_seen_q;
  id_t    s3_id_q;
  coord_t s3_x_q, s3_y_q;
  quat_t  s3_quat_q;

  coord_t robot_x_q, robot_y_q;
  logic   batch_started_q, batch_removed_q;
  logic   goal_active_q, active_removed_q;
  id_t    active_id_q;
  coord_t active_x_q, active_y_q;

  logic              best_valid_q;
  logic [DIST_W-1:0] best_dist_q;
  id_t               best_id_q;
  coord_t            best_x_q, best_y_q;
  quat_t             best_quat_q;

  logic [DIST_W-1:0] cand_dist, act_dist;
  logic              rd_new, rd_rem;
  id_t               raddr;
  mark_t             cur_wr, prev_wr_q;

  logic   s3_cand, take, fin_valid, batch_end, reached, emit;
  id_t    fin_id;
  coord_t fin_x, fin_y;
  quat_t  fin_quat;
  res_t   res_d, out_res;
  logic [$bits(res_t)-1:0] buf_data;

  // --------------------------------------------------------------------------
  // Threshold register (squared on write)
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_sq_q <= THR_SQ_RESET;
    end else if (cfg_i.valid) begin
      thr_sq_q <= THR_SQ_W'(cfg_i.data) * THR_SQ_W'(cfg_i.data);
    end
  end

  // --------------------------------------------------------------------------
  // Bitmap clearing pass after reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clear_q) begin
      clr_cnt_q <= clr_cnt_q + id_t'(1);
      if (clr_cnt_q == '1) begin
        clear_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input handshake and interlock
  // --------------------------------------------------------------------------
  assign adv        = !buf_full;
  assign last_busy  = (s1_v_q && s1_point_q && s1_last_q) ||
                      (s2_v_q && s2_point_q && s2_last_q);
  assign in_last_pt = (in_i.action == ACT_POINT) && in_i.last_in_batch;
  assign in_i.ready = !clear_q && adv && !(in_last_pt && last_busy);
  assign accept     = in_i.valid && in_i.ready;

  // --------------------------------------------------------------------------
  // Visited bitmaps, one per list; reread stage 1's entry while frozen
  // --------------------------------------------------------------------------
  assign raddr = adv ? in_i.point_id : s1_id_q;

  nugs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map_new (
    .clk_i   (clk_i),
    .we_i    (clear_q || (cur_wr.v && !cur_wr.rem)),
    .waddr_i (clear_q ? clr_cnt_q : cur_wr.addr),
    .wdata_i (!clear_q),
    .raddr_i (raddr),
    .rdata_o (rd_new)
  );

  nugs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map_rem (
    .clk_i   (clk_i),
    .we_i    (clear_q || (cur_wr.v && cur_wr.rem)),
    .waddr_i (clear_q ? clr_cnt_q : cur_wr.addr),
    .wdata_i (!clear_q),
    .raddr_i (raddr),
    .rdata_o (rd_rem)
  );

  // Write that landed at the edge of the last read, missed by read-first RAM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_wr_q <= '0;
    end else begin
      prev_wr_q <= cur_wr;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: bitmap data, batch list, robot position
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_point_q    <= (in_i.action == ACT_POINT);
      s1_last_q     <= in_i.last_in_batch;
      s1_add_q      <= in_i.is_add;
      s1_from_rem_q <= in_i.from_removed;
      s1_id_q       <= in_i.point_id;
      s1_x_q        <= in_i.pos_x;
      s1_y_q        <= in_i.pos_y;
      s1_quat_q     <= '{x: in_i.quat_x, y: in_i.quat_y, z: in_i.quat_z, w: in_i.quat_w};
    end
  end

  // List comes from the first item of the batch
  assign s1_rem  = batch_started_q ? batch_removed_q : s1_from_rem_q;
  assign s1_seen = (s1_rem ? rd_rem : rd_new) ||
                   wr_hit(prev_wr_q, s1_rem, s1_id_q) ||
                   wr_hit(cur_wr, s1_rem, s1_id_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_x_q       <= '0;
      robot_y_q       <= '0;
      batch_started_q <= 1'b0;
      batch_removed_q <= 1'b0;
    end else if (adv && s1_v_q) begin
      if (!s1_point_q) begin
        robot_x_q <= s1_x_q;
        robot_y_q <= s1_y_q;
      end else begin
        batch_started_q <= !s1_last_q;
        batch_removed_q <= s1_rem;
      end
    end
  end

  // Candidate and active-goal distances to the robot
  nugs_sqdist #(
    .COORD_BITS (COORD_BITS)
  ) u_cand_dist (
    .clk_i  (clk_i),
    .en_i   (adv),
    .ax_i   (robot_x_q),
    .ay_i   (robot_y_q),
    .bx_i   (s1_x_q),
    .by_i   (s1_y_q),
    .dist_o (cand_dist)
  );

  nugs_sqdist #(
    .COORD_BITS (COORD_BITS)
  ) u_act_dist (
    .clk_i  (clk_i),
    .en_i   (adv),
    .ax_i   (robot_x_q),
    .ay_i   (robot_y_q),
    .bx_i   (active_x_q),
    .by_i   (active_y_q),
    .dist_o (act_dist)
  );

  // --------------------------------------------------------------------------
  // Stage 2 and 3 sidecar registers
  // --------------------------------------------------------------------------
  assign s2_seen = s2_seen_q || wr_hit(cur_wr, s2_rem_q, s2_id_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_point_q <= s1_point_q;
      s2_last_q  <= s1_last_q;
      s2_add_q   <= s1_add_q;
      s2_rem_q   <= s1_rem;
      s2_seen_q  <= s1_seen;
      s2_id_q    <= s1_id_q;
      s2_x_q     <= s1_x_q;
      s2_y_q     <= s1_y_q;
      s2_quat_q  <= s1_quat_q;

      s3_point_q <= s2_point_q;
      s3_last_q  <= s2_last_q;
      s3_add_q   <= s2_add_q;
      s3_rem_q   <= s2_rem_q;
      s3_seen_q  <= s2_seen;
      s3_id_q    <= s2_id_q;
      s3_x_q     <= s2_x_q;
      s3_y_q     <= s2_y_q;
      s3_quat_q  <= s2_quat_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: running minimum, arrival check, goal decision
  // --------------------------------------------------------------------------
  always_comb begin
    s3_cand   = s3_v_q && s3_point_q;
    take      = s3_cand && s3_add_q && !s3_seen_q &&
                (!best_valid_q || (cand_dist < best_dist_q));
    fin_valid = best_valid_q || take;
    fin_id    = take ? s3_id_q   : best_id_q;
    fin_x     = take ? s3_x_q    : best_x_q;
    fin_y     = take ? s3_y_q    : best_y_q;
    fin_quat  = take ? s3_quat_q : best_quat_q;
    batch_end = s3_cand && s3_last_q;
    reached   = batch_end && goal_active_q &&
                (CMP_W'(act_dist) < CMP_W'(thr_sq_q));
    emit      = batch_end && fin_valid && !(goal_active_q && !reached);

    cur_wr.v    = adv && reached;
    cur_wr.rem  = active_removed_q;
    cur_wr.addr = active_id_q;

    res_d = '{id: fin_id, x: fin_x, y: fin_y, q: fin_quat,
              from_removed: s3_rem_q, reached: reached};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q     <= 1'b0;
      best_dist_q      <= '0;
      goal_active_q    <= 1'b0;
      active_removed_q <= 1'b0;
      active_id_q      <= '0;
      active_x_q       <= '0;
      active_y_q       <= '0;
    end else if (adv && s3_cand) begin
      if (s3_last_q) begin
        best_valid_q <= 1'b0;
        if (emit) begin
          goal_active_q    <= 1'b1;
          active_removed_q <= s3_rem_q;
          active_id_q      <= fin_id;
          active_x_q       <= fin_x;
          active_y_q       <= fin_y;
        end else if (reached) begin
          goal_active_q <= 1'b0;
        end
      end else if (take) begin
        best_valid_q <= 1'b1;
        best_dist_q  <= cand_dist;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && take) begin
      best_id_q   <= s3_id_q;
      best_x_q    <= s3_x_q;
      best_y_q    <= s3_y_q;
      best_quat_q <= s3_quat_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer and output channel
  // --------------------------------------------------------------------------
  nugs_outbuf #(
    .W ($bits(res_t))
  ) u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (adv && emit),
    .data_i  (res_d),
    .full_o  (buf_full),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (buf_data)
  );

  assign out_res                 = res_t'(buf_data);
  assign out_o.goal_id           = out_res.id;
  assign out_o.goal_x            = out_res.x;
  assign out_o.goal_y            = out_res.y;
  assign out_o.goal_qx           = out_res.q.x;
  assign out_o.goal_qy           = out_res.q.y;
  assign out_o.goal_qz           = out_res.q.z;
  assign out_o.goal_qw           = out_res.q.w;
  assign out_o.goal_from_removed = out_res.from_removed;
  assign out_o.previous_reached  = out_res.reached;

endmodule

// ===== hw/rtl/nugs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nugs_checker: port-level checks for the nearest unvisited goal selector
// Watches the channels for the reset clearing pass, the batch-end spacing
// and a held result; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module nugs_checker
  import nugs_pkg::*;
#(
  parameter int ID_BITS    = 12,
  parameter int COORD_BITS = 24
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input action_e                      in_action_i,
  input logic                         in_last_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic        [ID_BITS-1:0]    out_goal_id_i,
  input logic signed [COORD_BITS-1:0] out_goal_x_i
);

  logic last_acc;

  // Batch-ending candidate transaction
  assign last_acc = in_valid_i && in_ready_i && (in_action_i == ACT_POINT) && in_last_i;

  // Bitmaps are still being cleared right after reset
  a_ready_low_after_reset: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i
  ) else $error("input ready while visited bitmaps are being cleared");

  // Batch ends are spaced so the arrival check sees the latest goal
  a_last_gap_1: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    last_acc |=> !last_acc
  ) else $error("batch end accepted one cycle after another batch end");

  a_last_gap_2: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    last_acc |-> ##2 !last_acc
  ) else $error("batch end accepted two cycles after another batch end");

  // A waiting result stays put
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_goal_id_i) && $stable(out_goal_x_i)
  ) else $error("stalled result changed or vanished");

endmodule

bind nearest_unvisited_goal_selector nugs_checker #(
  .ID_BITS    (ID_BITS),
  .COORD_BITS (COORD_BITS)
) u_nugs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_action_i   (in_i.action),
  .in_last_i     (in_i.last_in_batch),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_goal_id_i (out_o.goal_id),
  .out_goal_x_i  (out_o.goal_x)
);
